### rtl/bcs_pkg.sv
// Types, command codes and field limit tables shared by the clock set controller.
package bcs_pkg;

   localparam int FIELD_COUNT = 7;
   localparam int FIELD_IDX_W = $clog2(FIELD_COUNT);
   localparam int MODE_W      = 3;
   localparam int HALT_BIT    = 7;

   localparam logic [2:0] CMD_LOAD       = 3'd0;
   localparam logic [2:0] CMD_MENU_SHORT = 3'd1;
   localparam logic [2:0] CMD_MENU_LONG  = 3'd2;
   localparam logic [2:0] CMD_UP         = 3'd3;
   localparam logic [2:0] CMD_DOWN       = 3'd4;

   localparam logic [MODE_W-1:0] MODE_RUN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LAST = 3'd7;

   localparam int FIDX_SECONDS = 0;
   localparam int FIDX_MINUTES = 1;
   localparam int FIDX_HOURS   = 2;
   localparam int FIDX_WEEKDAY = 3;
   localparam int FIDX_DATE    = 4;
   localparam int FIDX_MONTH   = 5;
   localparam int FIDX_YEAR    = 6;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] in_seconds;
      logic [6:0] in_minutes;
      logic [5:0] in_hours;
      logic [2:0] in_weekday;
      logic [5:0] in_date;
      logic [4:0] in_month;
      logic [7:0] in_year;
   } req_type;

   typedef struct packed {
      logic [2:0] mode_now;
      logic       commit;
      logic [7:0] out_seconds;
      logic [6:0] out_minutes;
      logic [5:0] out_hours;
      logic [2:0] out_weekday;
      logic [5:0] out_date;
      logic [4:0] out_month;
      logic [7:0] out_year;
   } rsp_type;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] lo;
      logic [7:0] hi;
      logic       down;
   } step_ctl_type;

   function automatic logic [7:0] field_min(input logic [FIELD_IDX_W-1:0] idx);
      logic [7:0] val;
      case (idx) inside
         3'd3, 3'd4, 3'd5, 3'd6: val = 8'h01;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] field_max(input logic [FIELD_IDX_W-1:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'h59;
         3'd1: val = 8'h59;
         3'd2: val = 8'h23;
         3'd3: val = 8'h07;
         3'd4: val = 8'h31;
         3'd5: val = 8'h12;
         3'd6: val = 8'h20;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] field_default(input logic [FIELD_IDX_W-1:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'h01;
         3'd1: val = 8'h40;
         3'd2: val = 8'h06;
         3'd3: val = 8'h03;
         3'd4: val = 8'h01;
         3'd5: val = 8'h12;
         3'd6: val = 8'h15;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### rtl/bcs_field_step.sv
// BCD up/down step of one clock field with wrap between its limits.
module bcs_field_step (
   input  bcs_pkg::step_ctl_type step_ctl,
   output logic [7:0]            step_out
);
   import bcs_pkg::*;

   always_comb begin
      if (step_ctl.down) begin
         if (step_ctl.value <= step_ctl.lo) begin
            step_out = step_ctl.hi;
         end else if (step_ctl.value[3:0] == 4'h0) begin
            step_out = step_ctl.value - 8'h07;
         end else begin
            step_out = step_ctl.value - 8'h01;
         end
      end else begin
         if (step_ctl.value >= step_ctl.hi) begin
            step_out = step_ctl.lo;
         end else if (step_ctl.value[3:0] == 4'h9) begin
            step_out = step_ctl.value + 8'h07;
         end else begin
            step_out = step_ctl.value + 8'h01;
         end
      end
   end

endmodule

### rtl/bcs_rsp_stage.sv
// Result register with valid/stall handshake toward the consumer.
module bcs_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bcs_pkg::rsp_type load_data,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bcs_pkg::rsp_type rsp_payload
);
   import bcs_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   assign can_load     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= load_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### rtl/bcd_clock_set_controller.sv
// Top level of the BCD clock set controller: mode and field registers plus command decode.
// A request's result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; req_stall rises only while the single result
// register holds a result that the consumer is stalling.
// Reset clears the setting mode and all seven fields to zero and drops any pending result.
module bcd_clock_set_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bcs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bcs_pkg::rsp_type rsp_payload
);
   import bcs_pkg::*;

   logic [MODE_W-1:0]      mode_ff;
   logic [MODE_W-1:0]      mode_in;
   logic [7:0]             fields_ff [FIELD_COUNT];
   logic [7:0]             fields_in [FIELD_COUNT];
   logic                   commit_in;
   logic                   req_accept;
   logic                   can_load;
   logic [FIELD_IDX_W-1:0] sel_idx;
   logic [7:0]             sel_value;
   logic [7:0]             step_out;
   step_ctl_type           step_ctl;
   rsp_type                rsp_data;

   assign req_stall  = !can_load;
   assign req_accept = req_valid && can_load;
   assign sel_idx    = FIELD_IDX_W'(mode_ff - 3'd1);

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         if (sel_idx == FIELD_IDX_W'(i)) begin
            sel_value = fields_ff[i];
         end
      end
   end

   assign step_ctl.value = sel_value;
   assign step_ctl.lo    = field_min(sel_idx);
   assign step_ctl.hi    = field_max(sel_idx);
   assign step_ctl.down  = (req_payload.command == CMD_DOWN);

   bcs_field_step u_step (
      .step_ctl (step_ctl),
      .step_out (step_out)
   );

   always_comb begin
      mode_in   = mode_ff;
      fields_in = fields_ff;
      commit_in = 1'b0;
      unique case (req_payload.command) inside
         CMD_LOAD: begin
            if (mode_ff == MODE_RUN) begin
               if (req_payload.in_seconds[HALT_BIT]) begin
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     fields_in[i] = field_default(FIELD_IDX_W'(i));
                  end
                  commit_in = 1'b1;
               end else begin
                  fields_in[FIDX_SECONDS] = req_payload.in_seconds;
                  fields_in[FIDX_MINUTES] = {1'b0, req_payload.in_minutes};
                  fields_in[FIDX_HOURS]   = {2'b0, req_payload.in_hours};
                  fields_in[FIDX_WEEKDAY] = {5'b0, req_payload.in_weekday};
                  fields_in[FIDX_DATE]    = {2'b0, req_payload.in_date};
                  fields_in[FIDX_MONTH]   = {3'b0, req_payload.in_month};
                  fields_in[FIDX_YEAR]    = req_payload.in_year;
               end
            end
         end
         CMD_MENU_SHORT: begin
            if (mode_ff == MODE_LAST) begin
               mode_in   = MODE_RUN;
               commit_in = 1'b1;
            end else begin
               mode_in = mode_ff + 3'd1;
            end
         end
         CMD_MENU_LONG: begin
            mode_in = MODE_RUN;
         end
         CMD_UP, CMD_DOWN: begin
            if (mode_ff != MODE_RUN) begin
               for (int i = 0; i < FIELD_COUNT; i++) begin
                  if (sel_idx == FIELD_IDX_W'(i)) begin
                     fields_in[i] = step_out;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RUN;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            fields_ff[i] <= '0;
         end
      end else if (req_accept) begin
         mode_ff   <= mode_in;
         fields_ff <= fields_in;
      end
   end

   assign rsp_data.mode_now    = mode_in;
   assign rsp_data.commit      = commit_in;
   assign rsp_data.out_seconds = fields_in[FIDX_SECONDS];
   assign rsp_data.out_minutes = fields_in[FIDX_MINUTES][6:0];
   assign rsp_data.out_hours   = fields_in[FIDX_HOURS][5:0];
   assign rsp_data.out_weekday = fields_in[FIDX_WEEKDAY][2:0];
   assign rsp_data.out_date    = fields_in[FIDX_DATE][5:0];
   assign rsp_data.out_month   = fields_in[FIDX_MONTH][4:0];
   assign rsp_data.out_year    = fields_in[FIDX_YEAR];

   bcs_rsp_stage u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (req_accept),
      .load_data   (rsp_data),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A commit is only ever reported together with the running mode.
   a_commit_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.commit || rsp_payload.mode_now == MODE_RUN))
      else $error("commit reported outside the running mode");

   // Every accepted request leaves a result in the output register.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no result");

   // The setting mode changes only when a request is accepted.
   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(mode_ff))
      else $error("setting mode changed without a request");

   // A short menu press below the last mode advances the mode by one.
   a_mode_advance: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.command == CMD_MENU_SHORT && mode_ff != MODE_LAST)
      |=> (mode_ff == $past(mode_ff) + 3'd1))
      else $error("short menu press did not advance the mode");

endmodule
